// File: rtl/bhs_pkg.sv
// Shared types and constants of the brightness histogram block.
// Holds the payload structs, the controller states and the bin geometry.
// No dependencies.
package bhs_pkg;

    // Bin geometry and counter width.
    localparam int LEVELS     = 256;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int COUNT_BITS = 24;

    typedef logic [LVL_W-1:0]      bin_addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam bin_addr_t LAST_BIN  = bin_addr_t'(LEVELS - 1);
    localparam count_t    COUNT_MAX = {COUNT_BITS{1'b1}};

    // Reciprocal of three for the color average, scaled by two to the eleventh.
    localparam int RECIP3_SHIFT = 11;
    localparam logic [10:0] RECIP3 = 11'd683;

    // One pixel transaction.
    typedef struct packed {
        logic [7:0] blue_or_gray;
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic       frame_start;
        logic       frame_end;
    } bhs_in_t;

    // One statistics transaction.
    typedef struct packed {
        logic [7:0]  mode_level;
        logic [23:0] mode_count;
        logic [7:0]  top_level;
        logic [7:0]  bottom_level;
        logic [23:0] pixel_count;
    } bhs_out_t;

    // One bin sample handed to the scan unit.
    typedef struct packed {
        logic      vld;
        bin_addr_t idx;
        count_t    cnt;
    } bhs_smp_t;

    // Running statistics of the scan unit.
    typedef struct packed {
        bin_addr_t mode_level;
        count_t    mode_count;
        bin_addr_t top_level;
        bin_addr_t bottom_level;
    } bhs_stats_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_RUN,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT
    } bhs_state_t;

endpackage

// File: rtl/brightness_histogram_stats.sv
// Brightness histogram statistics. Pixels are taken one per cycle while in_ready
// is high: the level (gray byte, or the truncated average of red, green and blue
// in color mode) is looked up in a 256-entry bin memory, incremented with
// saturation and written back the next cycle, with the last write forwarded so
// that equal levels in consecutive transactions count correctly. A frame start
// clears all bins at once through per-bin valid bits, so no clearing pass is
// needed after reset. A frame end makes the block stop taking pixels and scan the
// bin memory one bin per cycle through its single read port: in_ready stays low
// from the end pixel until the result is loaded, which waits for the previous
// result to be taken. color_mode may be written only while the block is idle.
// Depends on bhs_pkg, bhs_bin_ram and bhs_scan.
module brightness_histogram_stats (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  bhs_pkg::bhs_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bhs_pkg::bhs_out_t out_data
);
    import bhs_pkg::*;

    logic        color_mode_reg;
    logic        in_accept;

    bhs_state_t  state_reg;
    bhs_state_t  state_next;

    // Pixel level computation.
    logic [9:0]  rgb_sum;
    logic [20:0] rgb_prod;
    logic [7:0]  lvl_raw;
    bin_addr_t   lvl_addr;

    // Update stage registers.
    logic        s1_vld_reg;
    logic        s1_start_reg;
    logic        s1_end_reg;
    bin_addr_t   s1_addr_reg;

    // Last write, for forwarding.
    logic        fwd_vld_reg;
    bin_addr_t   fwd_addr_reg;
    count_t      fwd_data_reg;

    count_t      bin_old;
    count_t      bin_new;
    count_t      pix_reg;
    count_t      pix_base;
    count_t      pix_next;

    // Memory port signals.
    logic        rd_en;
    bin_addr_t   rd_addr;
    count_t      rd_data;

    // Scan sequencing.
    bin_addr_t   scan_idx_reg;
    logic        smp_vld_reg;
    bin_addr_t   smp_idx_reg;
    logic        scan_clr;
    logic        scan_go;
    logic        out_load;
    bhs_smp_t    smp;
    bhs_stats_t  stats;

    logic        out_valid_reg;
    bhs_out_t    out_data_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            color_mode_reg <= cfg_wr_data;
        end
    end

    // Input handshake: no new pixel from a frame end until its result is loaded.
    assign in_ready  = (state_reg == ST_RUN) && !(s1_vld_reg && s1_end_reg);
    assign in_accept = in_valid && in_ready;

    // Level: the color average divides by three through a reciprocal multiply.
    always_comb
    begin
        rgb_sum  = 10'(in_data.blue_or_gray) + 10'(in_data.green_level)
                 + 10'(in_data.red_level);
        rgb_prod = 21'(rgb_sum) * 21'(RECIP3);
        lvl_raw  = color_mode_reg ? rgb_prod[RECIP3_SHIFT +: 8] : in_data.blue_or_gray;
        if (lvl_raw > 8'(LEVELS - 1))
        begin
            lvl_addr = LAST_BIN;
        end
        else
        begin
            lvl_addr = lvl_raw[LVL_W-1:0];
        end
    end

    // Read port is shared between incoming pixels and the scan.
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            rd_en   = 1'b1;
            rd_addr = scan_idx_reg;
        end
        else
        begin
            rd_en   = in_accept;
            rd_addr = lvl_addr;
        end
    end

    bhs_bin_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (s1_vld_reg),
        .wr_clr  (s1_start_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (bin_new)
    );

    // Update stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_start_reg <= 1'b0;
            s1_end_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= in_accept;
            s1_start_reg <= in_accept && in_data.frame_start;
            s1_end_reg   <= in_accept && in_data.frame_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg <= lvl_addr;
        end
    end

    // Old bin value: a frame start counts from zero, else forward the last write.
    always_comb
    begin
        if (s1_start_reg)
        begin
            bin_old = '0;
        end
        else if (fwd_vld_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            bin_old = fwd_data_reg;
        end
        else
        begin
            bin_old = rd_data;
        end
        bin_new  = (bin_old == COUNT_MAX) ? bin_old : bin_old + 1'b1;
        pix_base = s1_start_reg ? '0 : pix_reg;
        pix_next = (pix_base == COUNT_MAX) ? pix_base : pix_base + 1'b1;
    end

    // Forwarding register and pixel counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg <= 1'b0;
            pix_reg     <= '0;
        end
        else if (s1_vld_reg)
        begin
            fwd_vld_reg <= 1'b1;
            pix_reg     <= pix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= bin_new;
        end
    end

    // Controller next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (s1_vld_reg && s1_end_reg)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_BIN)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        scan_clr = 1'b0;
        scan_go  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                scan_clr = s1_vld_reg && s1_end_reg;
            end
            ST_SCAN:
            begin
                scan_go = 1'b1;
            end
            ST_FLUSH:
            begin
                scan_go = 1'b0;
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                scan_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            scan_idx_reg <= '0;
            smp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            smp_vld_reg <= scan_go;
            if (scan_clr)
            begin
                scan_idx_reg <= '0;
            end
            else if (scan_go)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_go)
        begin
            smp_idx_reg <= scan_idx_reg;
        end
    end

    // Bin samples arrive in the cycle after their read.
    always_comb
    begin
        smp.vld = smp_vld_reg;
        smp.idx = smp_idx_reg;
        smp.cnt = rd_data;
    end

    bhs_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (scan_clr),
        .smp   (smp),
        .stats (stats)
    );

    // Result register: holds one transaction until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.mode_level   <= 8'(stats.mode_level);
            out_data_reg.mode_count   <= 24'(stats.mode_count);
            out_data_reg.top_level    <= 8'(stats.top_level);
            out_data_reg.bottom_level <= 8'(stats.bottom_level);
            out_data_reg.pixel_count  <= 24'(pix_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/bhs_bin_ram.sv
// Histogram bin memory: one write port, one registered read port.
// A valid bit per bin lets a frame start clear all bins at once.
// Depends on bhs_pkg.
module bhs_bin_ram (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  bhs_pkg::bin_addr_t rd_addr,
    output bhs_pkg::count_t    rd_data,
    input  logic              wr_en,
    input  logic              wr_clr,
    input  bhs_pkg::bin_addr_t wr_addr,
    input  bhs_pkg::count_t    wr_data
);
    import bhs_pkg::*;

    count_t            mem [LEVELS];
    count_t            rd_q_reg;
    bin_addr_t         rd_addr_reg;
    logic [LEVELS-1:0] valid_reg;
    logic [LEVELS-1:0] valid_next;
    logic [LEVELS-1:0] wr_onehot;

    // Storage array with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg    <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // A write marks its bin valid; a clearing write drops all other bins.
    always_comb
    begin
        wr_onehot = '0;
        wr_onehot[wr_addr] = 1'b1;
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next = wr_clr ? wr_onehot : (valid_reg | wr_onehot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // A bin that is not valid reads as zero, judged at the time of use.
    assign rd_data = valid_reg[rd_addr_reg] ? rd_q_reg : '0;

endmodule

// File: rtl/bhs_scan.sv
// End-of-frame scan unit: folds one bin per cycle into the statistics.
// Tracks the first largest bin and the lowest and highest occupied bins.
// Depends on bhs_pkg.
module bhs_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  bhs_pkg::bhs_smp_t   smp,
    output bhs_pkg::bhs_stats_t stats
);
    import bhs_pkg::*;

    bhs_stats_t stats_reg;
    bhs_stats_t stats_next;
    logic       seen_reg;
    logic       seen_next;

    // Compare the incoming bin against the running statistics.
    always_comb
    begin
        stats_next = stats_reg;
        seen_next  = seen_reg;
        if (clr)
        begin
            stats_next.mode_level   = '0;
            stats_next.mode_count   = '0;
            stats_next.top_level    = '0;
            stats_next.bottom_level = LAST_BIN;
            seen_next               = 1'b0;
        end
        else if (smp.vld)
        begin
            if (smp.cnt > stats_reg.mode_count)
            begin
                stats_next.mode_count = smp.cnt;
                stats_next.mode_level = smp.idx;
            end
            if (smp.cnt != '0)
            begin
                if (!seen_reg)
                begin
                    stats_next.bottom_level = smp.idx;
                end
                stats_next.top_level = smp.idx;
                seen_next            = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg.mode_level   <= '0;
            stats_reg.mode_count   <= '0;
            stats_reg.top_level    <= '0;
            stats_reg.bottom_level <= LAST_BIN;
            seen_reg               <= 1'b0;
        end
        else
        begin
            stats_reg <= stats_next;
            seen_reg  <= seen_next;
        end
    end

    assign stats = stats_reg;

endmodule
